// File: sv/skq_pkg.sv
// skq_pkg: shared types, codes and defaults for the sorted key queue
// no dependencies; used by every file of the block
`timescale 1ns / 1ps

package skq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int ITEM_WIDTH_DEF = 32;

  localparam int OPC_W    = 3;
  localparam int HANDLE_W = 32;
  localparam int KEY_W    = 64;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 5;

  // request opcodes
  localparam logic [OPC_W-1:0] OP_APPEND   = 3'd0;
  localparam logic [OPC_W-1:0] OP_PREPEND  = 3'd1;
  localparam logic [OPC_W-1:0] OP_SORTED   = 3'd2;
  localparam logic [OPC_W-1:0] OP_REM_HEAD = 3'd3;
  localparam logic [OPC_W-1:0] OP_REM_KEY  = 3'd4;
  localparam logic [OPC_W-1:0] OP_SEEK     = 3'd5;
  localparam logic [OPC_W-1:0] OP_PEEK     = 3'd6;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic [HANDLE_W-1:0]     item_handle;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [HANDLE_W-1:0]     item_out;
    logic signed [KEY_W-1:0] key_out;
    logic                    found;
    logic [OCC_W-1:0]        occupancy;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UP,
    S_PLACE,
    S_DOWN,
    S_DONE
  } state_t;

endpackage

// File: sv/skq_mem.sv
// skq_mem: entry store, one write port and one read port with registered data
// depends on skq_pkg for its parameter defaults; instantiated by sorted_key_queue
`timescale 1ns / 1ps

module skq_mem #(
  parameter int DEPTH = skq_pkg::DEPTH_DEF,
  parameter int WIDTH = skq_pkg::KEY_W + skq_pkg::ITEM_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/sorted_key_queue.sv
// sorted_key_queue: ordered queue of keyed items with a single compare unit
// depends on skq_pkg and skq_mem
`timescale 1ns / 1ps
//
// Usage: a request (cmd: opcode, item_handle, key) is taken at a rising edge
// with start high and busy low. busy stays high until the result has been
// shown. The result (status, item_out, key_out, found, occupancy) is on the
// result port for exactly one cycle while done is high; the receiver cannot
// hold it off, and the next request can be taken in the cycle after done.
// Entries sit in a one-read, one-write memory at positions 0 (head) up to
// occupancy-1. A search walks the entries from the head through one 64-bit
// compare unit, one entry per cycle; an insert or a removal then moves the
// entries behind the position one place, one entry per cycle.
// Append writes at the tail with no walk; prepend moves every entry; a
// sorted insert scans to the first larger key and moves the entries behind
// it; a removal scans to the hit and moves the entries behind it toward the
// head; seek and peek stop at the hit; a miss walks every entry; a refused
// insert or an unused opcode goes straight to done. The entry walk over the
// memory port sets how long a request takes.
// Reset empties the queue; the entry memory is not cleared.

module sorted_key_queue #(
  parameter int DEPTH      = skq_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = skq_pkg::ITEM_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  skq_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output skq_pkg::result_t result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (ITEM_WIDTH < skq_pkg::HANDLE_W) ? ITEM_WIDTH : skq_pkg::HANDLE_W;
  localparam int MW = SW + skq_pkg::KEY_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE      = CW'(1);

  skq_pkg::state_t state, state_next;

  logic [skq_pkg::OPC_W-1:0]        op;
  logic [SW-1:0]                    new_item;
  logic signed [skq_pkg::KEY_W-1:0] new_key;
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    ridx;
  logic [CW-1:0]                    pos;
  logic                             dv;

  logic [skq_pkg::STAT_W-1:0]       res_status;
  logic [SW-1:0]                    res_item;
  logic signed [skq_pkg::KEY_W-1:0] res_key;
  logic                             res_found;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [MW-1:0] rd_data;

  logic [SW-1:0]                    e_item;
  logic signed [skq_pkg::KEY_W-1:0] e_key;
  logic key_lt, key_eq, hit, cvalid, scan_end, full;
  logic [CW-1:0] ridx_inc, ridx_dec;

  skq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (MW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // shared compare unit on the entry just read
  assign e_item = rd_data[SW-1:0];
  assign e_key  = rd_data[MW-1:SW];
  assign key_lt = new_key < e_key;
  assign key_eq = new_key == e_key;

  assign ridx_inc = ridx + ONE;
  assign ridx_dec = ridx - ONE;
  assign cvalid   = ridx != '0;
  assign scan_end = ridx == count;
  assign full     = count >= FULL_CNT;

  always_comb begin
    case (op)
      skq_pkg::OP_SORTED:   hit = key_lt;
      skq_pkg::OP_REM_KEY:  hit = key_eq;
      skq_pkg::OP_SEEK:     hit = key_eq;
      skq_pkg::OP_REM_HEAD: hit = 1'b1;
      skq_pkg::OP_PEEK:     hit = 1'b1;
      default:              hit = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      skq_pkg::S_IDLE: begin
        if (start) begin
          case (cmd.opcode)
            skq_pkg::OP_APPEND,
            skq_pkg::OP_PREPEND:  state_next = full ? skq_pkg::S_DONE : skq_pkg::S_UP;
            skq_pkg::OP_SORTED:   state_next = full ? skq_pkg::S_DONE : skq_pkg::S_SCAN;
            skq_pkg::OP_REM_HEAD,
            skq_pkg::OP_REM_KEY,
            skq_pkg::OP_SEEK,
            skq_pkg::OP_PEEK:     state_next = skq_pkg::S_SCAN;
            default:              state_next = skq_pkg::S_DONE;
          endcase
        end
      end
      skq_pkg::S_SCAN: begin
        if (cvalid && hit) begin
          case (op)
            skq_pkg::OP_SORTED:   state_next = skq_pkg::S_UP;
            skq_pkg::OP_REM_HEAD,
            skq_pkg::OP_REM_KEY:  state_next = skq_pkg::S_DOWN;
            default:              state_next = skq_pkg::S_DONE;
          endcase
        end else if (scan_end) begin
          state_next = (op == skq_pkg::OP_SORTED) ? skq_pkg::S_UP : skq_pkg::S_DONE;
        end
      end
      skq_pkg::S_UP: begin
        if (ridx == pos) begin
          state_next = skq_pkg::S_PLACE;
        end
      end
      skq_pkg::S_PLACE: state_next = skq_pkg::S_DONE;
      skq_pkg::S_DOWN: begin
        if (!(ridx_inc < count)) begin
          state_next = skq_pkg::S_DONE;
        end
      end
      skq_pkg::S_DONE: state_next = skq_pkg::S_IDLE;
      default:         state_next = skq_pkg::S_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ridx[AW-1:0];
    mem_wdata = rd_data;
    mem_raddr = ridx[AW-1:0];
    busy      = 1'b1;
    done      = 1'b0;
    case (state)
      skq_pkg::S_IDLE: busy = 1'b0;
      skq_pkg::S_SCAN: mem_raddr = ridx[AW-1:0];
      skq_pkg::S_UP: begin
        // move entry ridx one place toward the tail
        mem_raddr = ridx_dec[AW-1:0];
        mem_we    = dv;
        mem_waddr = ridx_inc[AW-1:0];
      end
      skq_pkg::S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos[AW-1:0];
        mem_wdata = {new_key, new_item};
      end
      skq_pkg::S_DOWN: begin
        // move entry ridx one place toward the head
        mem_raddr = ridx_inc[AW-1:0];
        mem_we    = dv;
        mem_waddr = ridx_dec[AW-1:0];
      end
      skq_pkg::S_DONE: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skq_pkg::S_IDLE;
      count <= '0;
      ridx  <= '0;
      pos   <= '0;
      dv    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        skq_pkg::S_IDLE: begin
          if (start) begin
            op         <= cmd.opcode;
            new_item   <= cmd.item_handle[SW-1:0];
            new_key    <= (cmd.opcode == skq_pkg::OP_PREPEND) ? '0 : cmd.key;
            res_status <= skq_pkg::ST_OK;
            res_item   <= '0;
            res_key    <= '0;
            res_found  <= 1'b0;
            dv         <= 1'b0;
            case (cmd.opcode)
              skq_pkg::OP_APPEND: begin
                ridx <= count;
                pos  <= count;
                if (full) res_status <= skq_pkg::ST_FULL;
              end
              skq_pkg::OP_PREPEND: begin
                ridx <= count;
                pos  <= '0;
                if (full) res_status <= skq_pkg::ST_FULL;
              end
              skq_pkg::OP_SORTED: begin
                ridx <= '0;
                if (full) res_status <= skq_pkg::ST_FULL;
              end
              default: ridx <= '0;
            endcase
          end
        end
        skq_pkg::S_SCAN: begin
          if (cvalid && hit) begin
            dv <= 1'b0;
            case (op)
              skq_pkg::OP_SORTED: begin
                pos  <= ridx_dec;
                ridx <= count;
              end
              skq_pkg::OP_REM_HEAD,
              skq_pkg::OP_REM_KEY: begin
                res_item  <= e_item;
                res_key   <= e_key;
                res_found <= op == skq_pkg::OP_REM_KEY;
                ridx      <= ridx_dec;
              end
              skq_pkg::OP_SEEK: res_found <= 1'b1;
              default: begin
                res_item <= e_item;
                res_key  <= e_key;
              end
            endcase
          end else if (scan_end) begin
            dv <= 1'b0;
            if (op == skq_pkg::OP_SORTED) begin
              pos  <= count;
              ridx <= count;
            end else begin
              res_status <= skq_pkg::ST_MISS;
            end
          end else begin
            ridx <= ridx_inc;
          end
        end
        skq_pkg::S_UP: begin
          if (ridx != pos) begin
            ridx <= ridx_dec;
            dv   <= 1'b1;
          end
        end
        skq_pkg::S_PLACE: count <= count + ONE;
        skq_pkg::S_DOWN: begin
          if (ridx_inc < count) begin
            ridx <= ridx_inc;
            dv   <= 1'b1;
          end else begin
            count <= count - ONE;
          end
        end
        default: ;
      endcase
    end
  end

  assign result.status    = res_status;
  assign result.item_out  = skq_pkg::HANDLE_W'(res_item);
  assign result.key_out   = res_key;
  assign result.found     = res_found;
  assign result.occupancy = skq_pkg::OCC_W'(count);

endmodule

// File: sv/skq_checker.sv
// skq_assert: port-level assertions for sorted_key_queue, bound to the top level
// depends on skq_pkg and sorted_key_queue
`timescale 1ns / 1ps

module skq_assert (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input skq_pkg::result_t result
);

  // a taken item always leads to a busy period
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item accepted but busy not raised");

  // results only come out of a busy period, one cycle each
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy ##1 !done)
    else $error("done outside a busy period or longer than one cycle");

  // found implies a good status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.found |-> result.status == skq_pkg::ST_OK)
    else $error("found set with a failing status");

  // a failed request returns no entry
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != skq_pkg::ST_OK |-> result.item_out == '0 &&
      result.key_out == '0 && !result.found)
    else $error("failed request returned entry data");

endmodule

bind sorted_key_queue skq_assert u_skq_assert (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// File: test/skq_checker.sv
// skq_checker: keeps its own copy of the sorted key queue, predicts each answer
// and compares it with what the block returns; depends on skq_pkg
`timescale 1ns / 1ps

module skq_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  skq_pkg::cmd_t    cmd,
  input  logic             done,
  input  skq_pkg::result_t result,
  output int               errors,
  output int               waiting,
  output int               answered,
  output int               refused,
  output int               matched
);

  localparam int SLOTS = skq_pkg::DEPTH_DEF;

  logic [skq_pkg::HANDLE_W-1:0]     q_item [SLOTS];
  logic signed [skq_pkg::KEY_W-1:0] q_key [SLOTS];
  int                               q_len;
  skq_pkg::result_t                 due_results [$];
  skq_pkg::result_t                 want;
  skq_pkg::result_t                 next_want;

  function automatic void put_at(int pos, logic [skq_pkg::HANDLE_W-1:0] it,
                                 logic signed [skq_pkg::KEY_W-1:0] k);
    for (int i = q_len; i > pos; i--) begin
      q_item[i] = q_item[i-1];
      q_key[i]  = q_key[i-1];
    end
    q_item[pos] = it;
    q_key[pos]  = k;
    q_len++;
  endfunction

  function automatic void drop_at(int pos);
    for (int i = pos; i + 1 < q_len; i++) begin
      q_item[i] = q_item[i+1];
      q_key[i]  = q_key[i+1];
    end
    q_len--;
  endfunction

  // applies one request to the queue copy and returns the answer it gives
  function automatic skq_pkg::result_t apply_request(skq_pkg::cmd_t c);
    skq_pkg::result_t r;
    int               pos;
    r = '0;
    case (c.opcode)
      skq_pkg::OP_APPEND, skq_pkg::OP_PREPEND, skq_pkg::OP_SORTED: begin
        if (q_len >= SLOTS) begin
          r.status = skq_pkg::ST_FULL;
        end else if (c.opcode == skq_pkg::OP_APPEND) begin
          put_at(q_len, c.item_handle, c.key);
        end else if (c.opcode == skq_pkg::OP_PREPEND) begin
          put_at(0, c.item_handle, '0);
        end else begin
          // goes behind every entry with an equal key
          pos = 0;
          while (pos < q_len && !(c.key < q_key[pos])) pos++;
          put_at(pos, c.item_handle, c.key);
        end
      end
      skq_pkg::OP_REM_HEAD, skq_pkg::OP_PEEK: begin
        if (q_len == 0) begin
          r.status = skq_pkg::ST_MISS;
        end else begin
          r.item_out = q_item[0];
          r.key_out  = q_key[0];
          if (c.opcode == skq_pkg::OP_REM_HEAD) drop_at(0);
        end
      end
      skq_pkg::OP_REM_KEY, skq_pkg::OP_SEEK: begin
        r.status = skq_pkg::ST_MISS;
        pos = 0;
        while (pos < q_len && q_key[pos] !== c.key) pos++;
        if (pos < q_len) begin
          r.status = skq_pkg::ST_OK;
          r.found  = 1'b1;
          if (c.opcode == skq_pkg::OP_REM_KEY) begin
            r.item_out = q_item[pos];
            r.key_out  = q_key[pos];
            drop_at(pos);
          end
        end
      end
      default: ;
    endcase
    r.occupancy = skq_pkg::OCC_W'(q_len);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      q_len = 0;
      due_results.delete();
    end else begin
      if (done) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with none expected, status %0d occupancy %0d",
                   $time, result.status, result.occupancy);
          errors++;
        end else begin
          want = due_results.pop_front();
          answered++;
          if (result.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, result.status);
            errors++;
          end
          if (result.item_out !== want.item_out) begin
            $display("%0t: item_out expected %h got %h", $time, want.item_out,
                     result.item_out);
            errors++;
          end
          if (result.key_out !== want.key_out) begin
            $display("%0t: key_out expected %0d got %0d", $time, want.key_out,
                     result.key_out);
            errors++;
          end
          if (result.found !== want.found) begin
            $display("%0t: found expected %0d got %0d", $time, want.found, result.found);
            errors++;
          end
          if (result.occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d got %0d", $time, want.occupancy,
                     result.occupancy);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        next_want = apply_request(cmd);
        if (next_want.status == skq_pkg::ST_FULL) refused++;
        if (next_want.found) matched++;
        due_results.push_back(next_want);
      end
    end
    waiting = due_results.size();
  end

endmodule

// File: test/sorted_key_queue_tb.sv
// sorted_key_queue_tb: drives requests into the sorted key queue and gives the verdict
// depends on skq_pkg, sorted_key_queue and skq_checker
`timescale 1ns / 1ps

module sorted_key_queue_tb;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1330;
  localparam int TAIL_CYCLES  = 40;
  localparam logic [skq_pkg::OPC_W-1:0] OP_UNUSED = 3'd7;
  localparam logic signed [skq_pkg::KEY_W-1:0] KEY_MIN =
    {1'b1, {(skq_pkg::KEY_W-1){1'b0}}};
  localparam logic signed [skq_pkg::KEY_W-1:0] KEY_MAX =
    {1'b0, {(skq_pkg::KEY_W-1){1'b1}}};

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             done;
  skq_pkg::cmd_t    cmd;
  skq_pkg::result_t result;
  logic             gaps_on;
  int               errors, waiting, answered, refused, matched;
  int               stall_cycles = 0;
  int               mode;

  sorted_key_queue dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  skq_checker chk (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .result   (result),
    .errors   (errors),
    .waiting  (waiting),
    .answered (answered),
    .refused  (refused),
    .matched  (matched)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic skq_pkg::cmd_t mk(logic [skq_pkg::OPC_W-1:0] op,
                                       logic [skq_pkg::HANDLE_W-1:0] it,
                                       logic signed [skq_pkg::KEY_W-1:0] k);
    skq_pkg::cmd_t c;
    c.opcode      = op;
    c.item_handle = it;
    c.key         = k;
    return c;
  endfunction

  // mostly a small pool of keys so that seeks, removals and equal keys hit
  function automatic logic signed [skq_pkg::KEY_W-1:0] pick_key();
    int     v;
    longint k;
    v = $urandom_range(0, 9);
    case (v)
      7:       k = KEY_MIN;
      8:       k = KEY_MAX;
      9:       k = {$urandom, $urandom};
      default: k = v - 3;
    endcase
    return k;
  endfunction

  function automatic logic [skq_pkg::OPC_W-1:0] pick_op(int m);
    int roll;
    roll = $urandom_range(0, 99);
    case (m)
      MODE_FILL:
        if (roll < 75)
          return skq_pkg::OPC_W'($urandom_range(skq_pkg::OP_APPEND, skq_pkg::OP_SORTED));
        else
          return skq_pkg::OPC_W'($urandom_range(skq_pkg::OP_REM_HEAD, OP_UNUSED));
      MODE_DRAIN:
        if (roll < 75)
          return skq_pkg::OPC_W'($urandom_range(skq_pkg::OP_REM_HEAD, skq_pkg::OP_PEEK));
        else if (roll < 95)
          return skq_pkg::OPC_W'($urandom_range(skq_pkg::OP_APPEND, skq_pkg::OP_SORTED));
        else
          return OP_UNUSED;
      default:
        return skq_pkg::OPC_W'($urandom_range(skq_pkg::OP_APPEND, OP_UNUSED));
    endcase
  endfunction

  // entered and left at a falling edge; start stays high from item to item unless a gap is inserted
  task automatic issue(skq_pkg::cmd_t c);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    cmd     = '0;
    gaps_on = 1'b1;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // empty queue
    issue(mk(skq_pkg::OP_PEEK, 32'h0, 64'sd0));
    issue(mk(skq_pkg::OP_REM_HEAD, 32'hffff_ffff, KEY_MAX));
    issue(mk(skq_pkg::OP_REM_KEY, 32'h0, 64'sd5));
    issue(mk(skq_pkg::OP_SEEK, 32'h0, KEY_MIN));
    issue(mk(OP_UNUSED, 32'hffff_ffff, -64'sd1));
    // inserts at the key extremes; the prepend key is ignored
    issue(mk(skq_pkg::OP_APPEND, 32'hffff_ffff, KEY_MAX));
    issue(mk(skq_pkg::OP_APPEND, 32'h0, KEY_MIN));
    issue(mk(skq_pkg::OP_PREPEND, 32'h1234_5678, -64'sd1));
    issue(mk(skq_pkg::OP_SORTED, 32'h0000_0002, 64'sd0));
    issue(mk(skq_pkg::OP_SORTED, 32'h8000_0000, KEY_MIN));
    issue(mk(skq_pkg::OP_SORTED, 32'h7fff_ffff, KEY_MAX));
    // hits and misses
    issue(mk(skq_pkg::OP_SEEK, 32'hdead_beef, KEY_MAX));
    issue(mk(skq_pkg::OP_SEEK, 32'h0, 64'sd77));
    issue(mk(skq_pkg::OP_REM_KEY, 32'h0, 64'sd0));
    issue(mk(skq_pkg::OP_REM_KEY, 32'h0, 64'sd77));
    issue(mk(skq_pkg::OP_PEEK, 32'h0, 64'sd0));
    issue(mk(skq_pkg::OP_REM_HEAD, 32'h0, 64'sd0));
    issue(mk(OP_UNUSED, 32'h5555_aaaa, KEY_MAX));

    // random phases: filling runs reach a full queue, draining runs empty it
    mode = MODE_FILL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        mode    = $urandom_range(MODE_FILL, MODE_MIXED);
        gaps_on = (n < RANDOM_ITEMS * 4 / 5) && ($urandom_range(0, 3) != 0);
      end
      issue(mk(pick_op(mode), $urandom, pick_key()));
    end
    start <= 1'b0;

    while (waiting != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests answered and checked, all seven opcodes plus the unused one",
             answered);
    $display("%0d inserts refused on a full queue, %0d seek or removal key matches",
             refused, matched);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
